/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is held.
`define CNMS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define CNMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/cnms_pkg.sv */
// Types and constants of the four-direction non-maximum suppression block.
package cnms_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int PIXEL_BITS    = 12;
  localparam int VAL_BITS      = 12;
  localparam int CELL_BITS     = VAL_BITS + 2;
  localparam int MAG_BITS      = 25;
  localparam int ROW_BITS      = 13;
  localparam int CFG_BITS      = 13;
  localparam int DIAG_MUL      = 181;
  localparam int MIN_SIDE      = 5;
  localparam int MAX_HEIGHT    = 4096;

  localparam logic [1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_EDGE_THRESHOLD = 2'd2;

  localparam logic [1:0] DIR_E  = 2'd0;
  localparam logic [1:0] DIR_NE = 2'd1;
  localparam logic [1:0] DIR_N  = 2'd2;
  localparam logic [1:0] DIR_SE = 2'd3;

  typedef struct packed {
    logic                  action;
    logic [PIXEL_BITS-1:0] pixel_value;
  } in_t;

  typedef struct packed {
    logic                edge_res;
    logic                strong_res;
    logic [1:0]          direction;
    logic [MAG_BITS-1:0] magnitude;
    logic                frame_end;
  } out_t;

  // Per-item position flags worked out at the input.
  typedef struct packed {
    logic emit;
    logic fe;
    logic outer;
    logic inner;
    logic dvalid;
  } ctl_t;

endpackage

/* rtl/cnms_line_ram.sv */
// Simple dual-port line memory with registered read data.
module cnms_line_ram #(
  parameter int DEPTH = 2048,
  parameter int DW    = 24,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/canny_discrete_nms.sv */
// Top level: four-direction Canny non-maximum suppression on a pixel stream.
//
// Accepts one smoothed pixel per clock and gives at most one result per
// accepted item. The result of a pixel leaves on the item that enters two
// rows plus two pixels later (items 0 .. 2W+1 of a frame give none; send
// 2W+2 flush items after the last pixel to drain the tail). Inside the block
// an item passes through register stages: position bookkeeping and pixel line
// read, pixel window, differences and deriv line read, diagonal scaling and
// squares, dominant direction and deriv window, then threshold and
// suppression into the output register. All stages advance together, so
// the sustained rate is one item per clock; when a finished result is held
// by out_stall the whole pipe holds and in_stall rises. Line memories are
// one MAX_WIDTH deep RAM per window kind; they need no clearing after reset.
// Frame geometry follows image_width and image_height, clamped to
// [5, MAX_WIDTH] and [5, 4096]; write the registers only while idle.
module canny_discrete_nms #(
  parameter int MAX_WIDTH = cnms_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  cnms_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output cnms_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [cnms_pkg::CFG_BITS-1:0] cfg_wdata
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = cnms_pkg::ROW_BITS;
  localparam int PB  = cnms_pkg::PIXEL_BITS;
  localparam int VB  = cnms_pkg::VAL_BITS;
  localparam int CB  = cnms_pkg::CELL_BITS;
  localparam int MB  = cnms_pkg::MAG_BITS;
  localparam int DDW = 2 * CB + MB;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [11:0] cfg_width_r;
  logic [12:0] cfg_height_r;
  logic [11:0] cfg_thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= 12'd640;
      cfg_height_r <= 13'd480;
      cfg_thresh_r <= 12'd224;
    end else if (cfg_we) begin
      case (cfg_index)
        cnms_pkg::CFG_IMAGE_WIDTH:    cfg_width_r  <= cfg_wdata[11:0];
        cnms_pkg::CFG_IMAGE_HEIGHT:   cfg_height_r <= cfg_wdata[12:0];
        cnms_pkg::CFG_EDGE_THRESHOLD: cfg_thresh_r <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // Clamp the geometry.
  logic [WW-1:0] w_cl;
  logic [RW-1:0] h_cl;

  always_comb begin
    if (cfg_width_r < 12'(cnms_pkg::MIN_SIDE)) begin
      w_cl = WW'(cnms_pkg::MIN_SIDE);
    end else if ({20'd0, cfg_width_r} > 32'(MAX_WIDTH)) begin
      w_cl = WW'(MAX_WIDTH);
    end else begin
      w_cl = WW'(cfg_width_r);
    end
    if (cfg_height_r < 13'(cnms_pkg::MIN_SIDE)) begin
      h_cl = RW'(cnms_pkg::MIN_SIDE);
    end else if (cfg_height_r > 13'(cnms_pkg::MAX_HEIGHT)) begin
      h_cl = RW'(cnms_pkg::MAX_HEIGHT);
    end else begin
      h_cl = cfg_height_r;
    end
  end

  // ---------------------------------------------------------------------
  // Flow control: one enable for the whole pipe
  // ---------------------------------------------------------------------
  logic out_valid_r;
  logic adv;
  logic acc;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  // ---------------------------------------------------------------------
  // Stage 0: position counters, all decided at the input so that a
  // frame end resets the input side in step with the item stream
  // ---------------------------------------------------------------------
  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [WW-1:0] c_ext, ox_ext, w_m1;
  logic [RW-1:0] h_m1;
  logic [CW-1:0] di0;
  cnms_pkg::ctl_t ctl0;

  always_comb begin
    c_ext  = WW'(in_col_r);
    ox_ext = WW'(out_col_r);
    w_m1   = w_cl - WW'(1);
    h_m1   = h_cl - RW'(1);

    ctl0.dvalid = (in_col_r >= CW'(2)) && (c_ext <= w_m1) &&
                  (in_row_r >= RW'(2)) && (in_row_r <= h_m1);
    ctl0.emit   = (in_row_r > RW'(2)) || ((in_row_r == RW'(2)) && (in_col_r >= CW'(2)));
    ctl0.fe     = (ox_ext >= w_m1) && (out_row_r >= h_m1);
    ctl0.outer  = (out_col_r == '0) || (out_row_r == '0) ||
                  (ox_ext >= w_m1) || (out_row_r >= h_m1);
    ctl0.inner  = (out_col_r >= CW'(2)) &&
                  ({1'b0, ox_ext} + (WW+1)'(3) <= {1'b0, w_cl}) &&
                  (out_row_r >= RW'(2)) &&
                  ({1'b0, out_row_r} + (RW+1)'(3) <= {1'b0, h_cl});

    di0 = (in_col_r != '0) ? (in_col_r - CW'(1)) : w_m1[CW-1:0];

    // Advance the input position.
    if (c_ext + WW'(1) >= w_cl) begin
      in_col_nxt = '0;
      in_row_nxt = in_row_r + RW'(1);
    end else begin
      in_col_nxt = in_col_r + CW'(1);
      in_row_nxt = in_row_r;
    end

    // Advance the output position; a frame end restarts everything.
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (ctl0.emit) begin
      if (ctl0.fe) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (ox_ext + WW'(1) >= w_cl) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + RW'(1);
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (acc) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: pixel and the two pixel lines above it
  // ---------------------------------------------------------------------
  logic           v1_r;
  logic [PB-1:0]  p1_r;
  logic [CW-1:0]  ci1_r, di1_r;
  cnms_pkg::ctl_t ctl1_r;
  logic [2*PB-1:0] prd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p1_r   <= in_data.action ? '0 : in_data.pixel_value;
      ci1_r  <= in_col_r;
      di1_r  <= di0;
      ctl1_r <= ctl0;
    end
  end

  // Entry layout: {older line, newer line}.
  cnms_line_ram #(
    .DEPTH(MAX_WIDTH),
    .DW   (2 * PB),
    .AW   (CW)
  ) u_pix_ram (
    .clk  (clk),
    .we   (adv && v1_r),
    .waddr(ci1_r),
    .wdata({prd[PB-1:0], p1_r}),
    .re   (acc),
    .raddr(in_col_r),
    .rdata(prd)
  );

  // ---------------------------------------------------------------------
  // Stage 2: pixel window (column 2 newest, row 2 current line)
  // ---------------------------------------------------------------------
  logic [PB-1:0]  pw_r [3][3];
  logic           v2_r;
  logic [CW-1:0]  di2_r;
  cnms_pkg::ctl_t ctl2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          pw_r[k][j] <= '0;
        end
      end
    end else if (adv) begin
      v2_r <= v1_r;
      if (v1_r) begin
        for (int k = 0; k < 3; k++) begin
          pw_r[k][0] <= pw_r[k][1];
          pw_r[k][1] <= pw_r[k][2];
        end
        pw_r[0][2] <= prd[2*PB-1:PB];
        pw_r[1][2] <= prd[PB-1:0];
        pw_r[2][2] <= p1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      di2_r  <= di1_r;
      ctl2_r <= ctl1_r;
    end
  end

  function automatic logic [PB-1:0] absdiff(input logic [PB-1:0] a, input logic [PB-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // ---------------------------------------------------------------------
  // Stage 3: absolute differences, deriv line read
  // ---------------------------------------------------------------------
  logic           v3_r;
  logic [PB-1:0]  e3_r, n3_r, ned3_r, sed3_r;
  cnms_pkg::ctl_t ctl3_r;
  logic [CW-1:0]  di3_r;
  logic [DDW-1:0] drd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e3_r   <= absdiff(pw_r[1][2], pw_r[1][0]);
      n3_r   <= absdiff(pw_r[0][1], pw_r[2][1]);
      ned3_r <= absdiff(pw_r[0][2], pw_r[2][0]);
      sed3_r <= absdiff(pw_r[2][2], pw_r[0][0]);
      ctl3_r <= ctl2_r;
      di3_r  <= di2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: diagonal scaling and squares
  // ---------------------------------------------------------------------
  localparam int SPW = PB + 8;

  logic           v4_r;
  logic [VB-1:0]  e4_r, n4_r, ne4_r, se4_r;
  logic [2*PB-1:0] sqe4_r, sqn4_r;
  cnms_pkg::ctl_t ctl4_r;
  logic [CW-1:0]  di4_r;
  logic [DDW-1:0] dr4_r;
  logic [SPW-1:0] ne_prod, se_prod;

  assign ne_prod = SPW'(ned3_r) * SPW'(cnms_pkg::DIAG_MUL) + SPW'(128);
  assign se_prod = SPW'(sed3_r) * SPW'(cnms_pkg::DIAG_MUL) + SPW'(128);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e4_r   <= VB'(e3_r);
      n4_r   <= VB'(n3_r);
      ne4_r  <= VB'(ne_prod[SPW-1:8]);
      se4_r  <= VB'(se_prod[SPW-1:8]);
      sqe4_r <= (2*PB)'(e3_r) * (2*PB)'(e3_r);
      sqn4_r <= (2*PB)'(n3_r) * (2*PB)'(n3_r);
      ctl4_r <= ctl3_r;
      di4_r  <= di3_r;
      dr4_r  <= drd;
    end
  end

  // Dominant direction with strict-greater ties.
  logic [CB-1:0] cell4;
  logic [MB-1:0] mag4;

  always_comb begin
    if (e4_r > ne4_r && e4_r > n4_r && e4_r > se4_r) begin
      cell4 = {cnms_pkg::DIR_E, e4_r};
    end else if (ne4_r > n4_r && ne4_r > se4_r) begin
      cell4 = {cnms_pkg::DIR_NE, ne4_r};
    end else if (n4_r > se4_r) begin
      cell4 = {cnms_pkg::DIR_N, n4_r};
    end else begin
      cell4 = {cnms_pkg::DIR_SE, se4_r};
    end
    mag4 = MB'(sqe4_r) + MB'(sqn4_r);
    if (!ctl4_r.dvalid) begin
      cell4 = '0;
      mag4  = '0;
    end
  end

  // Entry layout: {older deriv line, newer deriv line, delayed magnitude}.
  cnms_line_ram #(
    .DEPTH(MAX_WIDTH),
    .DW   (DDW),
    .AW   (CW)
  ) u_drv_ram (
    .clk  (clk),
    .we   (adv && v4_r),
    .waddr(di4_r),
    .wdata({dr4_r[CB+MB-1:MB], cell4, mag4}),
    .re   (adv && v2_r),
    .raddr(di2_r),
    .rdata(drd)
  );

  // ---------------------------------------------------------------------
  // Stage 5: deriv window and magnitude delay
  // ---------------------------------------------------------------------
  logic [CB-1:0]  dw_r [3][3];
  logic [MB-1:0]  mag_hold_r, omag5_r;
  logic           v5_r;
  cnms_pkg::ctl_t ctl5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r       <= 1'b0;
      mag_hold_r <= '0;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          dw_r[k][j] <= '0;
        end
      end
    end else if (adv) begin
      v5_r <= v4_r;
      if (v4_r) begin
        for (int k = 0; k < 3; k++) begin
          dw_r[k][0] <= dw_r[k][1];
          dw_r[k][1] <= dw_r[k][2];
        end
        dw_r[0][2] <= dr4_r[DDW-1:CB+MB];
        dw_r[1][2] <= dr4_r[CB+MB-1:MB];
        dw_r[2][2] <= cell4;
        mag_hold_r <= dr4_r[MB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl5_r <= ctl4_r;
      if (v4_r) begin
        omag5_r <= mag_hold_r;
      end
    end
  end

  // Threshold and suppression along the dominant direction.
  logic [VB-1:0] val5, fwd5, bwd5;
  logic [1:0]    dir5;
  cnms_pkg::out_t res5;

  always_comb begin
    val5 = dw_r[1][1][VB-1:0];
    dir5 = dw_r[1][1][CB-1:VB];
    case (dir5)
      cnms_pkg::DIR_E: begin
        fwd5 = dw_r[1][2][VB-1:0];
        bwd5 = dw_r[1][0][VB-1:0];
      end
      cnms_pkg::DIR_NE: begin
        fwd5 = dw_r[0][2][VB-1:0];
        bwd5 = dw_r[2][0][VB-1:0];
      end
      cnms_pkg::DIR_N: begin
        fwd5 = dw_r[0][1][VB-1:0];
        bwd5 = dw_r[2][1][VB-1:0];
      end
      default: begin
        fwd5 = dw_r[2][2][VB-1:0];
        bwd5 = dw_r[0][0][VB-1:0];
      end
    endcase
    res5.strong_res = ctl5_r.inner && (val5 >= cfg_thresh_r);
    res5.edge_res   = res5.strong_res && (val5 > fwd5) && (val5 >= bwd5);
    res5.direction  = ctl5_r.outer ? 2'd0 : dir5;
    res5.magnitude  = ctl5_r.outer ? '0 : omag5_r;
    res5.frame_end  = ctl5_r.fe;
  end

  // ---------------------------------------------------------------------
  // Output register: drop items that make no result
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v5_r && ctl5_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= res5;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/cnms_checker.sv */
// Port-level checks for the non-maximum suppression block, bound to the top.
`include "assert_macros.svh"

module cnms_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input cnms_pkg::out_t out_data,
  input logic           out_valid,
  input logic           out_stall
);

  `CNMS_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped")
  `CNMS_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_data), "held result moved")
  `CNMS_ASSERT(a_edge_strong, clk, rst_n, out_valid && out_data.edge_res |-> out_data.strong_res, "weak edge")
  `CNMS_ASSERT_ALWAYS(a_stall_cause, clk, in_stall |-> (out_valid && out_stall), "input held without cause")
  `CNMS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "result after reset")

endmodule

bind canny_discrete_nms cnms_checker u_cnms_checker (.*);

/* tb/sv/tb_canny_discrete_nms.sv */
// Self-checking testbench for the four-direction Canny non-maximum suppression block.
`timescale 1ns / 1ps

module tb_canny_discrete_nms;

  localparam int LINE_W     = 2048;
  localparam int DRAIN_LAT  = 20;    // cycles to let the pipe settle once results are in
  localparam int LONG_HOLD  = 300;   // receiver hold-off that fills the pipe
  localparam int WDOG_LIMIT = 2000;  // cycles without any transfer before giving up
  localparam int SMALL_ITEMS = 1900;

  // How a directed row is checked.
  typedef enum logic [1:0] {CHK_PRED, CHK_ZERO, CHK_LAST} chk_e;

  typedef struct packed {
    logic       action;
    logic [11:0] pix;
    chk_e       chk;
  } vec_t;

  // One derivative entry: dominant direction and dominant derivative.
  typedef struct packed {
    logic [1:0]  dir;
    logic [11:0] val;
  } grad_t;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  cnms_pkg::in_t  in_data;
  logic   out_valid;
  logic   out_stall;
  cnms_pkg::out_t out_data;
  logic   cfg_we;
  logic [1:0] cfg_index;
  logic [cnms_pkg::CFG_BITS-1:0] cfg_wdata;

  canny_discrete_nms dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor state: its own copy of registers, line memories and windows
  // ---------------------------------------------------------------------
  logic [11:0] cur_width;
  logic [12:0] cur_height;
  logic [11:0] cur_thresh;
  logic [11:0] pix_line [2][LINE_W];
  grad_t       grad_line[2][LINE_W];
  logic [24:0] mag_line [LINE_W];
  logic [24:0] mag_hold;
  logic [11:0] pix_win  [3][3];
  grad_t       grad_win [3][3];
  int unsigned in_x, in_y, res_x, res_y;

  cnms_pkg::out_t expected_results[$];

  int errors;
  int items_sent;
  int small_items;
  bit quiet;
  int hold_req_cnt;

  function automatic int unsigned abs_diff(int unsigned a, int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int unsigned diag_scale(int unsigned d);
    return (d * 181 + 128) >> 8;
  endfunction

  function automatic int unsigned eff_width();
    return (cur_width < cnms_pkg::MIN_SIDE) ? cnms_pkg::MIN_SIDE :
           ((cur_width > LINE_W) ? LINE_W : cur_width);
  endfunction

  function automatic int unsigned eff_height();
    return (cur_height < cnms_pkg::MIN_SIDE) ? cnms_pkg::MIN_SIDE :
           ((cur_height > cnms_pkg::MAX_HEIGHT) ? cnms_pkg::MAX_HEIGHT : cur_height);
  endfunction

  function automatic void reset_predictor();
    cur_width  = 12'd640;
    cur_height = 13'd480;
    cur_thresh = 12'd224;
    for (int i = 0; i < LINE_W; i++) begin
      pix_line[0][i] = '0; pix_line[1][i] = '0;
      grad_line[0][i] = '0; grad_line[1][i] = '0;
      mag_line[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        pix_win[i][j] = '0; grad_win[i][j] = '0;
      end
    mag_hold = '0;
    in_x = 0; in_y = 0; res_x = 0; res_y = 0;
  endfunction

  // Advance the model by one accepted item; return 1 with the result if one leaves.
  function automatic bit nms_predict(cnms_pkg::in_t d, output cnms_pkg::out_t o);
    int unsigned w, h, p, c, r, ci, dc, di, e, n, ne, se, ox, oy;
    logic [11:0] val, fwd, bwd;
    logic [1:0] dir;
    grad_t gcell, ctr;
    logic [24:0] mag, omag;
    int dx, dy;
    bit emit, outer, fe, strong_ok, edge_ok;
    w = eff_width();
    h = eff_height();
    p = d.action ? 0 : d.pixel_value;
    c = in_x; r = in_y;
    ci = c % LINE_W;
    o = '0;

    // pixel window: column 2 is the newest
    for (int k = 0; k < 3; k++) begin
      pix_win[k][0] = pix_win[k][1];
      pix_win[k][1] = pix_win[k][2];
    end
    pix_win[0][2] = pix_line[1][ci];
    pix_win[1][2] = pix_line[0][ci];
    pix_win[2][2] = 12'(p);
    pix_line[1][ci] = pix_line[0][ci];
    pix_line[0][ci] = 12'(p);

    gcell = '0;
    mag = '0;
    if (c >= 2 && c <= w - 1 && r >= 2 && r <= h - 1) begin
      e  = abs_diff(pix_win[1][2], pix_win[1][0]);
      n  = abs_diff(pix_win[0][1], pix_win[2][1]);
      ne = diag_scale(abs_diff(pix_win[0][2], pix_win[2][0]));
      se = diag_scale(abs_diff(pix_win[2][2], pix_win[0][0]));
      if (e > ne && e > n && e > se) begin
        val = 12'(e); dir = cnms_pkg::DIR_E;
      end else if (ne > n && ne > se) begin
        val = 12'(ne); dir = cnms_pkg::DIR_NE;
      end else if (n > se) begin
        val = 12'(n); dir = cnms_pkg::DIR_N;
      end else begin
        val = 12'(se); dir = cnms_pkg::DIR_SE;
      end
      gcell.val = val;
      gcell.dir = dir;
      mag = 25'(e * e + n * n);
    end

    dc = (c >= 1) ? c - 1 : w - 1;
    di = dc % LINE_W;
    for (int k = 0; k < 3; k++) begin
      grad_win[k][0] = grad_win[k][1];
      grad_win[k][1] = grad_win[k][2];
    end
    grad_win[0][2] = grad_line[1][di];
    grad_win[1][2] = grad_line[0][di];
    grad_win[2][2] = gcell;
    grad_line[1][di] = grad_line[0][di];
    grad_line[0][di] = gcell;
    omag = mag_hold;
    mag_hold = mag_line[di];
    mag_line[di] = mag;

    emit = (r > 2) || (r == 2 && c >= 2);
    in_x++;
    if (in_x >= w) begin
      in_x = 0; in_y++;
    end
    if (!emit) return 1'b0;

    ox = res_x; oy = res_y;
    ctr = grad_win[1][1];
    outer = (ox == 0 || oy == 0 || ox >= w - 1 || oy >= h - 1);
    strong_ok = 1'b0;
    edge_ok = 1'b0;
    if (ox >= 2 && ox + 3 <= w && oy >= 2 && oy + 3 <= h) begin
      case (ctr.dir)
        cnms_pkg::DIR_E:  begin dx = 1; dy = 0;  end
        cnms_pkg::DIR_NE: begin dx = 1; dy = -1; end
        cnms_pkg::DIR_N:  begin dx = 0; dy = -1; end
        default:          begin dx = 1; dy = 1;  end
      endcase
      fwd = grad_win[1 + dy][1 + dx].val;
      bwd = grad_win[1 - dy][1 - dx].val;
      strong_ok = ctr.val >= cur_thresh;
      edge_ok = strong_ok && ctr.val > fwd && ctr.val >= bwd;
    end
    fe = (ox >= w - 1 && oy >= h - 1);
    o.edge_res   = edge_ok;
    o.strong_res = strong_ok;
    o.direction  = outer ? 2'd0 : ctr.dir;
    o.magnitude  = outer ? '0 : omag;
    o.frame_end  = fe;

    // the frame's last result sends every counter back to the frame start
    if (fe) begin
      in_x = 0; in_y = 0; res_x = 0; res_y = 0;
    end else begin
      res_x++;
      if (res_x >= w) begin
        res_x = 0; res_y++;
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Offer one item, hold it until the transfer, then predict.
  task automatic send_item(logic action, logic [11:0] pix, chk_e chk);
    cnms_pkg::in_t d;
    cnms_pkg::out_t o;
    bit got;
    d.action = action;
    d.pixel_value = pix;
    in_data  <= d;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    got = nms_predict(d, o);
    if (chk == CHK_ZERO) begin
      expected_results.push_back('0);
    end else if (chk == CHK_LAST) begin
      o = '0;
      o.frame_end = 1'b1;
      expected_results.push_back(o);
    end else if (got) begin
      expected_results.push_back(o);
    end
    // random sender gap, dropped in the quiet tail of the run
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every expected result is back, then let the pipe settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_LAT) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [cnms_pkg::CFG_BITS-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      cnms_pkg::CFG_IMAGE_WIDTH:    cur_width  = value[11:0];
      cnms_pkg::CFG_IMAGE_HEIGHT:   cur_height = value[12:0];
      cnms_pkg::CFG_EDGE_THRESHOLD: cur_thresh = value[11:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Send one whole frame of generated content plus the flush items that drain it.
  task automatic send_frame(int mode, bit press, bit count_small);
    int unsigned w, h;
    int a, b, base, noise_max, cut, lo, hi, v;
    logic act;
    w = eff_width();
    h = eff_height();
    a = int'($urandom_range(0, 600)) - 300;
    b = int'($urandom_range(0, 600)) - 300;
    base = int'($urandom_range(0, 4095));
    noise_max = int'($urandom_range(0, 31));
    cut = int'($urandom_range(0, 40)) - 20;
    lo = int'($urandom_range(0, 4095));
    hi = int'($urandom_range(0, 4095));
    for (int unsigned y = 0; y < h; y++) begin
      for (int unsigned x = 0; x < w; x++) begin
        case (mode)
          0: v = int'($urandom_range(0, 4095));
          1: v = base + a * (int'(x) - 3) + b * (int'(y) - 3) +
                 int'($urandom_range(0, noise_max));
          default: v = ((a / 100) * int'(x) + (b / 100) * int'(y) > cut) ? hi : lo;
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        // now and then a flush item inside the frame, read as a zero pixel
        act = ($urandom_range(0, 49) == 0);
        // fill the pipe: receiver holds off while items keep coming
        if (press && y == 2 && x == 0) hold_req_cnt <= hold_req_cnt + 1;
        send_item(act, v[11:0], CHK_PRED);
        if (count_small) small_items++;
      end
    end
    // drain the tail; some pixel items after the frame end act as flush
    for (int unsigned k = 0; k < 2 * w + 2; k++) begin
      if ($urandom_range(0, 9) == 0) send_item(1'b0, 12'($urandom_range(0, 4095)), CHK_PRED);
      else send_item(1'b1, 12'($urandom_range(0, 4095)), CHK_PRED);
      if (count_small) small_items++;
    end
  endtask

  // 5x5 directed frame: extreme pixels, a flush inside the frame, typed zeros on the
  // outer ring and the frame-end result; the rest goes through the predictor.
  vec_t dir_tab [37] = '{
    '{1'b0, 12'd0,    CHK_PRED}, '{1'b0, 12'd4095, CHK_PRED}, '{1'b0, 12'd0,    CHK_PRED},
    '{1'b0, 12'd4095, CHK_PRED}, '{1'b0, 12'd0,    CHK_PRED},
    '{1'b0, 12'd4095, CHK_PRED}, '{1'b0, 12'd0,    CHK_PRED}, '{1'b0, 12'd4095, CHK_PRED},
    '{1'b0, 12'd0,    CHK_PRED}, '{1'b0, 12'd4095, CHK_PRED},
    '{1'b0, 12'd0,    CHK_PRED}, '{1'b0, 12'd0,    CHK_PRED}, '{1'b0, 12'd4095, CHK_ZERO},
    '{1'b0, 12'd4095, CHK_ZERO}, '{1'b0, 12'd4095, CHK_ZERO},
    '{1'b0, 12'd1,    CHK_ZERO}, '{1'b0, 12'd2048, CHK_ZERO}, '{1'b0, 12'd4095, CHK_ZERO},
    '{1'b0, 12'd2047, CHK_PRED}, '{1'b1, 12'd4095, CHK_PRED},
    '{1'b0, 12'd4095, CHK_PRED}, '{1'b0, 12'd4095, CHK_ZERO}, '{1'b0, 12'd0,    CHK_ZERO},
    '{1'b0, 12'd0,    CHK_PRED}, '{1'b0, 12'd1,    CHK_PRED},
    '{1'b1, 12'd0,    CHK_PRED}, '{1'b1, 12'd0,    CHK_ZERO}, '{1'b1, 12'd0,    CHK_ZERO},
    '{1'b1, 12'd0,    CHK_PRED}, '{1'b1, 12'd0,    CHK_PRED}, '{1'b1, 12'd0,    CHK_PRED},
    '{1'b1, 12'd0,    CHK_ZERO}, '{1'b1, 12'd0,    CHK_ZERO}, '{1'b1, 12'd0,    CHK_ZERO},
    '{1'b1, 12'd0,    CHK_ZERO}, '{1'b1, 12'd0,    CHK_ZERO}, '{1'b1, 12'd0,    CHK_LAST}
  };

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int f;
    int wsel;
    logic [cnms_pkg::CFG_BITS-1:0] wv, hv, tv;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = cnms_pkg::CFG_IMAGE_WIDTH;
    cfg_wdata    = '0;
    errors       = 0;
    items_sent   = 0;
    small_items  = 0;
    quiet        = 1'b0;
    hold_req_cnt = 0;
    reset_predictor();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed frame
    write_reg(cnms_pkg::CFG_IMAGE_WIDTH, 13'd5);
    write_reg(cnms_pkg::CFG_IMAGE_HEIGHT, 13'd5);
    write_reg(cnms_pkg::CFG_EDGE_THRESHOLD, 13'd0);
    foreach (dir_tab[i]) send_item(dir_tab[i].action, dir_tab[i].pix, dir_tab[i].chk);
    wait_idle();

    // random frames; a few take register values that clamp or lose their upper bit
    f = 0;
    while (f < 9 || small_items < SMALL_ITEMS) begin
      wait_idle();
      case (f)
        1: begin wv = 13'd0;     hv = 13'd0; end
        3: begin wv = 13'h1006;  hv = 13'd5; end
        5: begin wv = 13'd4;     hv = 13'd4; end
        7: begin wv = 13'd5;     hv = 13'd1; end
        default: begin
          wsel = int'($urandom_range(0, 9));
          wv = (wsel == 0) ? 13'($urandom_range(0, 4)) :
               (wsel == 1) ? 13'($urandom_range(13, 40)) : 13'($urandom_range(5, 12));
          hv = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 4)) :
                                              13'($urandom_range(5, 9));
        end
      endcase
      case ($urandom_range(0, 3))
        0: tv = 13'd0;
        1: tv = 13'd4095;
        2: tv = 13'($urandom_range(0, 300));
        default: tv = 13'($urandom_range(0, 4095));
      endcase
      if ($urandom_range(0, 3) == 0) tv[12] = 1'b1;  // upper bit is not stored
      write_reg(cnms_pkg::CFG_IMAGE_WIDTH, wv);
      write_reg(cnms_pkg::CFG_IMAGE_HEIGHT, hv);
      write_reg(cnms_pkg::CFG_EDGE_THRESHOLD, tv);
      if (f >= 9 && small_items > SMALL_ITEMS - 300) quiet = 1'b1;
      send_frame(int'($urandom_range(0, 2)), (f == 2 || f == 6), !(f inside {1, 3, 5, 7}));
      f++;
    end

    wait_idle();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver: compare each transfer and drive random stall bursts
  // ---------------------------------------------------------------------
  int stall_left;
  int hold_left;
  int hold_seen;
  initial begin
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
  end

  always @(posedge clk) begin
    cnms_pkg::out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        if (errors < 10) $display("unexpected result %h", out_data);
        errors++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data !== exp_res) begin
          if (errors < 10)
            $display({"mismatch: exp edge=%b strong=%b dir=%0d mag=%0d fe=%b,",
                      " got edge=%b strong=%b dir=%0d mag=%0d fe=%b"},
                     exp_res.edge_res, exp_res.strong_res, exp_res.direction,
                     exp_res.magnitude, exp_res.frame_end,
                     out_data.edge_res, out_data.strong_res, out_data.direction,
                     out_data.magnitude, out_data.frame_end);
          errors++;
        end
      end
    end
    // pick the stall level for the next cycle
    if (hold_req_cnt != hold_seen) begin
      hold_seen = hold_req_cnt;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rst_n && !quiet && $urandom_range(0, 7) == 0) begin
      stall_left = int'($urandom_range(0, 7));
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run if nothing transfers for too long.
  int idle_cycles;
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/cnms_pkg.sv
rtl/cnms_line_ram.sv
rtl/canny_discrete_nms.sv
rtl/cnms_checker.sv
tb/sv/tb_canny_discrete_nms.sv
